### hw/rtl/rmj_pkg.sv
// Shared types, constants and the output clipping function for the radar
// measurement Jacobian pipeline. No dependencies.
`timescale 1ns / 1ps

package rmj_pkg;

    localparam int FRONT_STAGES = 3;
    localparam int ROOT_STAGES  = 32;
    localparam int CUBE_STAGES  = 2;
    localparam int QW           = 33;

    localparam logic        REG_NEAR_ZERO = 1'b0;
    localparam logic [15:0] LIMIT_RESET   = 16'd7;

    localparam logic [QW-1:0] POS_LIM = 33'h0_7FFF_FFFF;
    localparam logic [QW-1:0] NEG_LIM = 33'h0_8000_0000;

    typedef struct packed {
        logic pxneg;
        logic pyneg;
        logic pypos;
        logic dneg;
        logic too_close;
    } t_flags;

    typedef struct packed {
        logic [31:0] apx;
        logic [31:0] apy;
        logic [63:0] c1;
        logic [63:0] dmag;
        t_flags      flg;
    } t_side;

    typedef struct packed {
        logic [31:0] val;
        logic        sat;
    } t_sat;

    function automatic t_sat sat_q(input logic [QW-1:0] q, input logic neg);
        t_sat          r;
        logic [QW-1:0] lim;
        logic [31:0]   m;
        lim = neg ? NEG_LIM : POS_LIM;
        if (q > lim) begin
            r.sat = 1'b1;
            m     = lim[31:0];
        end else begin
            r.sat = 1'b0;
            m     = q[31:0];
        end
        r.val = neg ? (32'd0 - m) : m;
        return r;
    endfunction

endpackage

### hw/rtl/rmj_state_if.sv
// Input item channel: one state sample (position and velocity, signed fixed point).
// Depends on nothing.
`timescale 1ns / 1ps

interface rmj_state_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;

    modport source (output valid, pos_x, pos_y, vel_x, vel_y, input ready);
    modport sink   (input valid, pos_x, pos_y, vel_x, vel_y, output ready);
endinterface

### hw/rtl/rmj_jac_if.sv
// Result item channel: the six distinct Jacobian entries and two status flags.
// Depends on nothing.
`timescale 1ns / 1ps

interface rmj_jac_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] range_by_px;
    logic signed [31:0] range_by_py;
    logic signed [31:0] bearing_by_px;
    logic signed [31:0] bearing_by_py;
    logic signed [31:0] rate_by_px;
    logic signed [31:0] rate_by_py;
    logic               too_close;
    logic               saturated;

    modport source (output valid, range_by_px, range_by_py, bearing_by_px, bearing_by_py,
                    rate_by_px, rate_by_py, too_close, saturated, input ready);
    modport sink   (input valid, range_by_px, range_by_py, bearing_by_px, bearing_by_py,
                    rate_by_px, rate_by_py, too_close, saturated, output ready);
endinterface

### hw/rtl/radar_measurement_jacobian_unit.sv
// Radar measurement Jacobian unit. Takes one state item per cycle and returns
// the range, bearing and range-rate partials through 3 front stages,
// 32 square-root stages, 2 multiply stages, 33 divider stages and the output
// register. The depth is set by the bit-per-stage square root and dividers;
// throughput is one item per clock. A stalled output holds the whole pipeline.
// Depends on rmj_pkg, rmj_state_if, rmj_jac_if and the rmj_* stage modules.
`timescale 1ns / 1ps

module radar_measurement_jacobian_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rmj_state_if.sink   i_state,
    rmj_jac_if.source   o_jac,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int QW    = rmj_pkg::QW;
    localparam int DEPTH = rmj_pkg::FRONT_STAGES + rmj_pkg::ROOT_STAGES
                         + rmj_pkg::CUBE_STAGES + QW + 1;
    localparam int N0_W  = 32 + FRAC_BITS;
    localparam int N2_W  = 32 + 2 * FRAC_BITS;
    localparam int N4_W  = 96 + FRAC_BITS;

    logic             en;
    logic [DEPTH-1:0] r_vld;
    logic [15:0]      r_limit;

    rmj_pkg::t_side   front_side, root_side;
    logic [31:0]      root;
    logic [63:0]      c1;
    logic [31:0]      c2, apx, apy;
    logic [95:0]      c3, pyd, pxd;
    rmj_pkg::t_flags  cube_flg;
    rmj_pkg::t_flags  r_flg [0:QW-1];

    logic [N0_W-1:0]  num_x1, num_y1;
    logic [N2_W-1:0]  num_x2, num_y2;
    logic [N4_W-1:0]  num_y4, num_x4;
    logic [QW-1:0]    q0, q1, q2, q3, q4, q5;

    rmj_pkg::t_sat    s0, s1, s2, s3, s4, s5;
    logic [31:0]      n_e0, n_e1, n_e2, n_e3, n_e4, n_e5;
    logic             n_sat;
    logic [31:0]      r_e0, r_e1, r_e2, r_e3, r_e4, r_e5;
    logic             r_close, r_sat;

    assign en            = !r_vld[DEPTH-1] || o_jac.ready;
    assign i_state.ready = en;

    // config port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == rmj_pkg::REG_NEAR_ZERO) ? {16'd0, r_limit} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= rmj_pkg::LIMIT_RESET;
        end else if (psel && penable && pwrite && paddr[2] == rmj_pkg::REG_NEAR_ZERO) begin
            r_limit <= pwdata[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[DEPTH-2:0], i_state.valid};
        end
    end

    rmj_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_pos_x (i_state.pos_x),
        .i_pos_y (i_state.pos_y),
        .i_vel_x (i_state.vel_x),
        .i_vel_y (i_state.vel_y),
        .i_limit (r_limit),
        .o_side  (front_side)
    );

    rmj_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_side (front_side),
        .o_root (root),
        .o_side (root_side)
    );

    rmj_cube u_cube (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_root (root),
        .i_side (root_side),
        .o_c1   (c1),
        .o_c2   (c2),
        .o_c3   (c3),
        .o_pyd  (pyd),
        .o_pxd  (pxd),
        .o_apx  (apx),
        .o_apy  (apy),
        .o_flg  (cube_flg)
    );

    assign num_x1 = N0_W'(apx) << FRAC_BITS;
    assign num_y1 = N0_W'(apy) << FRAC_BITS;
    assign num_x2 = N2_W'(apx) << (2 * FRAC_BITS);
    assign num_y2 = N2_W'(apy) << (2 * FRAC_BITS);
    assign num_y4 = N4_W'(pyd) << FRAC_BITS;
    assign num_x4 = N4_W'(pxd) << FRAC_BITS;

    rmj_div #(.NUM_W(N0_W), .DEN_W(32)) u_div_rx (
        .i_clk (i_clk), .i_en (en), .i_num (num_x1), .i_den (c2), .o_q (q0));
    rmj_div #(.NUM_W(N0_W), .DEN_W(32)) u_div_ry (
        .i_clk (i_clk), .i_en (en), .i_num (num_y1), .i_den (c2), .o_q (q1));
    rmj_div #(.NUM_W(N2_W), .DEN_W(64)) u_div_bx (
        .i_clk (i_clk), .i_en (en), .i_num (num_y2), .i_den (c1), .o_q (q2));
    rmj_div #(.NUM_W(N2_W), .DEN_W(64)) u_div_by (
        .i_clk (i_clk), .i_en (en), .i_num (num_x2), .i_den (c1), .o_q (q3));
    rmj_div #(.NUM_W(N4_W), .DEN_W(96)) u_div_tx (
        .i_clk (i_clk), .i_en (en), .i_num (num_y4), .i_den (c3), .o_q (q4));
    rmj_div #(.NUM_W(N4_W), .DEN_W(96)) u_div_ty (
        .i_clk (i_clk), .i_en (en), .i_num (num_x4), .i_den (c3), .o_q (q5));

    // flags ride alongside the dividers
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_flg[0] <= cube_flg;
            for (int k = 1; k < QW; k++) begin
                r_flg[k] <= r_flg[k-1];
            end
        end
    end

    always_comb begin
        s0 = rmj_pkg::sat_q(q0, r_flg[QW-1].pxneg);
        s1 = rmj_pkg::sat_q(q1, r_flg[QW-1].pyneg);
        s2 = rmj_pkg::sat_q(q2, r_flg[QW-1].pypos);
        s3 = rmj_pkg::sat_q(q3, r_flg[QW-1].pxneg);
        s4 = rmj_pkg::sat_q(q4, r_flg[QW-1].pyneg != r_flg[QW-1].dneg);
        s5 = rmj_pkg::sat_q(q5, r_flg[QW-1].pxneg == r_flg[QW-1].dneg);
        if (r_flg[QW-1].too_close) begin
            n_e0  = '0;
            n_e1  = '0;
            n_e2  = '0;
            n_e3  = '0;
            n_e4  = '0;
            n_e5  = '0;
            n_sat = 1'b0;
        end else begin
            n_e0  = s0.val;
            n_e1  = s1.val;
            n_e2  = s2.val;
            n_e3  = s3.val;
            n_e4  = s4.val;
            n_e5  = s5.val;
            n_sat = s0.sat | s1.sat | s2.sat | s3.sat | s4.sat | s5.sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e0    <= n_e0;
            r_e1    <= n_e1;
            r_e2    <= n_e2;
            r_e3    <= n_e3;
            r_e4    <= n_e4;
            r_e5    <= n_e5;
            r_close <= r_flg[QW-1].too_close;
            r_sat   <= n_sat;
        end
    end

    assign o_jac.valid         = r_vld[DEPTH-1];
    assign o_jac.range_by_px   = r_e0;
    assign o_jac.range_by_py   = r_e1;
    assign o_jac.bearing_by_px = r_e2;
    assign o_jac.bearing_by_py = r_e3;
    assign o_jac.rate_by_px    = r_e4;
    assign o_jac.rate_by_py    = r_e5;
    assign o_jac.too_close     = r_close;
    assign o_jac.saturated     = r_sat;

`ifndef SYNTHESIS
    localparam logic signed [31:0] UNIT = 32'sh1 << FRAC_BITS;

    a_close_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_jac.valid && o_jac.too_close |-> !o_jac.saturated &&
            o_jac.range_by_px == 0 && o_jac.range_by_py == 0 &&
            o_jac.bearing_by_px == 0 && o_jac.bearing_by_py == 0 &&
            o_jac.rate_by_px == 0 && o_jac.rate_by_py == 0)
        else $error("near-range item carries nonzero entries");

    a_range_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_jac.valid |-> o_jac.range_by_px <= UNIT && o_jac.range_by_px >= -UNIT &&
            o_jac.range_by_py <= UNIT && o_jac.range_by_py >= -UNIT)
        else $error("range partial exceeds unit magnitude");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_vld))
        else $error("pipeline valid bits moved during a stall");
`endif

endmodule

### hw/rtl/rmj_front.sv
// Front stages: magnitudes, cross products, squares, c1 and the near-range test.
// Depends on rmj_pkg.
`timescale 1ns / 1ps

module rmj_front #(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_vel_x,
    input  logic signed [31:0] i_vel_y,
    input  logic [15:0]        i_limit,
    output rmj_pkg::t_side     o_side
);

    logic [31:0]        n1_apx, n1_apy, r1_apx, r1_apy;
    logic signed [63:0] n1_a, n1_b, r1_a, r1_b;
    rmj_pkg::t_flags    n1_flg, r1_flg;

    logic [63:0]        n2_sqx, n2_sqy, r2_sqx, r2_sqy;
    logic signed [63:0] n2_diff;
    logic [63:0]        n2_dmag, r2_dmag;
    logic [31:0]        r2_apx, r2_apy;
    rmj_pkg::t_flags    n2_flg, r2_flg;

    logic [63:0]        n3_c1, n3_thr;
    rmj_pkg::t_side     n3_side, r3_side;

    always_comb begin
        n1_apx           = i_pos_x[31] ? 32'(-i_pos_x) : 32'(i_pos_x);
        n1_apy           = i_pos_y[31] ? 32'(-i_pos_y) : 32'(i_pos_y);
        n1_a             = 64'(i_vel_x) * 64'(i_pos_y);
        n1_b             = 64'(i_vel_y) * 64'(i_pos_x);
        n1_flg           = '0;
        n1_flg.pxneg     = i_pos_x[31];
        n1_flg.pyneg     = i_pos_y[31];
        n1_flg.pypos     = !i_pos_y[31] && (i_pos_y != 32'sd0);
    end

    always_comb begin
        n2_sqx      = 64'(r1_apx) * 64'(r1_apx);
        n2_sqy      = 64'(r1_apy) * 64'(r1_apy);
        n2_diff     = r1_a - r1_b;
        n2_flg      = r1_flg;
        n2_flg.dneg = r1_a < r1_b;
        n2_dmag     = n2_flg.dneg ? 64'(-n2_diff) : 64'(n2_diff);
    end

    always_comb begin
        n3_c1                 = r2_sqx + r2_sqy;
        n3_thr                = 64'(i_limit) << FRAC_BITS;
        n3_side.apx           = r2_apx;
        n3_side.apy           = r2_apy;
        n3_side.c1            = n3_c1;
        n3_side.dmag          = r2_dmag;
        n3_side.flg           = r2_flg;
        n3_side.flg.too_close = (n3_c1 == 64'd0) || (n3_c1 < n3_thr);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_apx  <= n1_apx;
            r1_apy  <= n1_apy;
            r1_a    <= n1_a;
            r1_b    <= n1_b;
            r1_flg  <= n1_flg;
            r2_sqx  <= n2_sqx;
            r2_sqy  <= n2_sqy;
            r2_dmag <= n2_dmag;
            r2_apx  <= r1_apx;
            r2_apy  <= r1_apy;
            r2_flg  <= n2_flg;
            r3_side <= n3_side;
        end
    end

    assign o_side = r3_side;

endmodule

### hw/rtl/rmj_isqrt.sv
// Pipelined integer square root of c1, one result bit per stage; carries the
// item's side data alongside. Depends on rmj_pkg.
`timescale 1ns / 1ps

module rmj_isqrt (
    input  logic           i_clk,
    input  logic           i_en,
    input  rmj_pkg::t_side i_side,
    output logic [31:0]    o_root,
    output rmj_pkg::t_side o_side
);

    localparam int N = rmj_pkg::ROOT_STAGES;

    logic [63:0]    a_x   [0:N-1];
    logic [63:0]    a_res [0:N-1];
    rmj_pkg::t_side a_side[0:N-1];
    logic [63:0]    sub   [0:N-1];
    logic           ge    [0:N-1];
    logic [63:0]    n_res [0:N-1];
    logic [63:0]    n_x   [0:N-2];

    logic [63:0]    r_x   [0:N-2];
    logic [63:0]    r_res [0:N-1];
    rmj_pkg::t_side r_side[0:N-1];

    always_comb begin
        a_x[0]   = i_side.c1;
        a_res[0] = '0;
        a_side[0] = i_side;
        for (int k = 1; k < N; k++) begin
            a_x[k]    = r_x[k-1];
            a_res[k]  = r_res[k-1];
            a_side[k] = r_side[k-1];
        end
        for (int k = 0; k < N; k++) begin
            sub[k]   = a_res[k] + (64'd1 << (62 - 2 * k));
            ge[k]    = a_x[k] >= sub[k];
            n_res[k] = ge[k] ? ((a_res[k] >> 1) + (64'd1 << (62 - 2 * k))) : (a_res[k] >> 1);
        end
        for (int k = 0; k < N - 1; k++) begin
            n_x[k] = ge[k] ? (a_x[k] - sub[k]) : a_x[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < N; k++) begin
                r_res[k]  <= n_res[k];
                r_side[k] <= a_side[k];
            end
            for (int k = 0; k < N - 1; k++) begin
                r_x[k] <= n_x[k];
            end
        end
    end

    assign o_root = r_res[N-1][31:0];
    assign o_side = r_side[N-1];

endmodule

### hw/rtl/rmj_cube.sv
// c3 = c1*c2 and the range-rate numerator products, as 32x32 partial products
// summed in a second stage. Depends on rmj_pkg.
`timescale 1ns / 1ps

module rmj_cube (
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [31:0]     i_root,
    input  rmj_pkg::t_side  i_side,
    output logic [63:0]     o_c1,
    output logic [31:0]     o_c2,
    output logic [95:0]     o_c3,
    output logic [95:0]     o_pyd,
    output logic [95:0]     o_pxd,
    output logic [31:0]     o_apx,
    output logic [31:0]     o_apy,
    output rmj_pkg::t_flags o_flg
);

    logic [63:0]     r1_c1lo, r1_c1hi, r1_ydlo, r1_ydhi, r1_xdlo, r1_xdhi;
    logic [63:0]     r1_c1;
    logic [31:0]     r1_c2, r1_apx, r1_apy;
    rmj_pkg::t_flags r1_flg;

    logic [95:0]     n2_c3, n2_pyd, n2_pxd;
    logic [95:0]     r2_c3, r2_pyd, r2_pxd;
    logic [63:0]     r2_c1;
    logic [31:0]     r2_c2, r2_apx, r2_apy;
    rmj_pkg::t_flags r2_flg;

    always_comb begin
        n2_c3  = {r1_c1hi, 32'd0} + 96'(r1_c1lo);
        n2_pyd = {r1_ydhi, 32'd0} + 96'(r1_ydlo);
        n2_pxd = {r1_xdhi, 32'd0} + 96'(r1_xdlo);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_c1lo <= 64'(i_side.c1[31:0])   * 64'(i_root);
            r1_c1hi <= 64'(i_side.c1[63:32])  * 64'(i_root);
            r1_ydlo <= 64'(i_side.dmag[31:0])  * 64'(i_side.apy);
            r1_ydhi <= 64'(i_side.dmag[63:32]) * 64'(i_side.apy);
            r1_xdlo <= 64'(i_side.dmag[31:0])  * 64'(i_side.apx);
            r1_xdhi <= 64'(i_side.dmag[63:32]) * 64'(i_side.apx);
            r1_c1   <= i_side.c1;
            r1_c2   <= i_root;
            r1_apx  <= i_side.apx;
            r1_apy  <= i_side.apy;
            r1_flg  <= i_side.flg;
            r2_c3   <= n2_c3;
            r2_pyd  <= n2_pyd;
            r2_pxd  <= n2_pxd;
            r2_c1   <= r1_c1;
            r2_c2   <= r1_c2;
            r2_apx  <= r1_apx;
            r2_apy  <= r1_apy;
            r2_flg  <= r1_flg;
        end
    end

    assign o_c1  = r2_c1;
    assign o_c2  = r2_c2;
    assign o_c3  = r2_c3;
    assign o_pyd = r2_pyd;
    assign o_pxd = r2_pxd;
    assign o_apx = r2_apx;
    assign o_apy = r2_apy;
    assign o_flg = r2_flg;

endmodule

### hw/rtl/rmj_div.sv
// Pipelined restoring divider, one quotient bit per stage, 33 quotient bits;
// bit 32 set means the quotient is out of range. Depends on rmj_pkg.
`timescale 1ns / 1ps

module rmj_div #(
    parameter int NUM_W = 48,
    parameter int DEN_W = 32
) (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic [NUM_W-1:0]       i_num,
    input  logic [DEN_W-1:0]       i_den,
    output logic [rmj_pkg::QW-1:0] o_q
);

    localparam int QW = rmj_pkg::QW;
    localparam int W  = (NUM_W > DEN_W + QW) ? NUM_W : DEN_W + QW;

    logic [W-1:0]     a_rem [0:QW-1];
    logic [DEN_W-1:0] a_den [0:QW-1];
    logic [QW-1:0]    a_q   [0:QW-1];
    logic [W-1:0]     dsh   [0:QW-1];
    logic             ge    [0:QW-1];
    logic [QW-1:0]    n_q   [0:QW-1];
    logic [W-1:0]     n_rem [0:QW-2];

    logic [W-1:0]     r_rem [0:QW-2];
    logic [DEN_W-1:0] r_den [0:QW-2];
    logic [QW-1:0]    r_q   [0:QW-1];

    always_comb begin
        a_rem[0] = W'(i_num);
        a_den[0] = i_den;
        a_q[0]   = '0;
        for (int k = 1; k < QW; k++) begin
            a_rem[k] = r_rem[k-1];
            a_den[k] = r_den[k-1];
            a_q[k]   = r_q[k-1];
        end
        for (int k = 0; k < QW; k++) begin
            dsh[k] = W'(a_den[k]) << (QW - 1 - k);
            ge[k]  = a_rem[k] >= dsh[k];
            n_q[k] = {a_q[k][QW-2:0], ge[k]};
        end
        for (int k = 0; k < QW - 1; k++) begin
            n_rem[k] = ge[k] ? (a_rem[k] - dsh[k]) : a_rem[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < QW; k++) begin
                r_q[k] <= n_q[k];
            end
            for (int k = 0; k < QW - 1; k++) begin
                r_rem[k] <= n_rem[k];
                r_den[k] <= a_den[k];
            end
        end
    end

    assign o_q = r_q[QW-1];

endmodule

### tb/radar_measurement_jacobian_checker.sv
// Checker for the radar measurement Jacobian unit: it watches the state, result
// and register channels, predicts each result and compares field by field.
// Depends on rmj_state_if and rmj_jac_if.
`timescale 1ns / 1ps

module radar_measurement_jacobian_checker #(
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rmj_state_if        st,
    rmj_jac_if          jac,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output int          o_errors,
    output int          o_pending,
    output int          o_results,
    output int          o_close_seen,
    output int          o_sat_seen
);

    typedef struct {
        logic [31:0] ent [6];
        logic        too_close;
        logic        saturated;
    } jac_t;

    jac_t        jac_expected [$];
    logic [15:0] limit_copy;
    string       ent_names [6] = '{"range_by_px", "range_by_py", "bearing_by_px",
                                   "bearing_by_py", "rate_by_px", "rate_by_py"};

    function automatic logic [32:0] clip_div(input logic [127:0] num,
                                             input logic [127:0] den, input logic neg);
        logic [127:0] q;
        logic [31:0]  lim;
        logic [31:0]  m;
        logic         s;
        q   = num / den;
        lim = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        s   = q > {96'd0, lim};
        m   = s ? lim : q[31:0];
        return {s, neg ? 32'd0 - m : m};
    endfunction

    function automatic logic [63:0] root_floor(input logic [63:0] x);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b   = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= res + b) begin
                x   = x - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic jac_t jacobian_of(input logic signed [31:0] px, input logic signed [31:0] py,
                                         input logic signed [31:0] vx, input logic signed [31:0] vy,
                                         input logic [15:0] lim);
        jac_t               r;
        logic [31:0]        apx;
        logic [31:0]        apy;
        logic [63:0]        c1;
        logic [63:0]        c2;
        logic [127:0]       c3;
        logic signed [64:0] d;
        logic [63:0]        dmag;
        logic               dneg;
        logic [32:0]        q [6];
        apx = px[31] ? 32'd0 - px : px;
        apy = py[31] ? 32'd0 - py : py;
        c1  = {32'd0, apx} * {32'd0, apx} + {32'd0, apy} * {32'd0, apy};
        r.too_close = 1'b0;
        r.saturated = 1'b0;
        if (c1 == 0 || c1 < ({48'd0, lim} << FRAC_BITS)) begin
            foreach (r.ent[j]) r.ent[j] = 0;
            r.too_close = 1'b1;
            return r;
        end
        c2   = root_floor(c1);
        c3   = {64'd0, c1} * {64'd0, c2};
        d    = 65'(64'(vx) * 64'(py)) - 65'(64'(vy) * 64'(px));
        dneg = d < 0;
        dmag = dneg ? 64'(-d) : 64'(d);
        q[0] = clip_div({96'd0, apx} << FRAC_BITS, {64'd0, c2}, px < 0);
        q[1] = clip_div({96'd0, apy} << FRAC_BITS, {64'd0, c2}, py < 0);
        q[2] = clip_div({96'd0, apy} << (2 * FRAC_BITS), {64'd0, c1}, py > 0);
        q[3] = clip_div({96'd0, apx} << (2 * FRAC_BITS), {64'd0, c1}, px < 0);
        q[4] = clip_div(({96'd0, apy} * {64'd0, dmag}) << FRAC_BITS, c3, (py < 0) != dneg);
        q[5] = clip_div(({96'd0, apx} * {64'd0, dmag}) << FRAC_BITS, c3, (px < 0) == dneg);
        foreach (q[j]) begin
            r.ent[j]    = q[j][31:0];
            r.saturated = r.saturated | q[j][32];
        end
        return r;
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("%0t mismatch %s: got %h, expected %h", $realtime, what, got, want);
        o_errors++;
    endtask

    initial begin
        o_errors     = 0;
        o_pending    = 0;
        o_results    = 0;
        o_close_seen = 0;
        o_sat_seen   = 0;
        limit_copy   = 16'd7;
    end

    always @(posedge i_clk) begin
        jac_t        w;
        logic [31:0] got [6];
        if (!i_rst_n) begin
            limit_copy <= 16'd7;
        end else begin
            if (jac.valid && jac.ready) begin
                got = '{jac.range_by_px, jac.range_by_py, jac.bearing_by_px,
                        jac.bearing_by_py, jac.rate_by_px, jac.rate_by_py};
                o_results++;
                if (jac_expected.size() == 0) begin
                    report("unexpected item", 32'd0, 32'd0);
                end else begin
                    w = jac_expected.pop_front();
                    foreach (got[j]) if (got[j] !== w.ent[j]) report(ent_names[j], got[j], w.ent[j]);
                    if (jac.too_close !== w.too_close)
                        report("too_close", 32'(jac.too_close), 32'(w.too_close));
                    if (jac.saturated !== w.saturated)
                        report("saturated", 32'(jac.saturated), 32'(w.saturated));
                    if (w.too_close) o_close_seen++;
                    if (w.saturated) o_sat_seen++;
                end
            end
            if (st.valid && st.ready)
                jac_expected.push_back(jacobian_of(st.pos_x, st.pos_y, st.vel_x, st.vel_y,
                                                   limit_copy));
            if (psel && penable && pwrite && pready && paddr[2] == 1'b0)
                limit_copy <= pwdata[15:0];
        end
        o_pending = jac_expected.size();
    end

endmodule

### tb/radar_measurement_jacobian_unit_test.sv
// Top of the radar measurement Jacobian testbench: clock, reset, register
// writes, state items and stalls; verdict from the checker's error count.
// Depends on rmj_state_if, rmj_jac_if, the unit and the checker.
`timescale 1ns / 1ps

module radar_measurement_jacobian_unit_test;

    localparam int WATCHDOG = 5000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;
    int          errors, pending, results, close_seen, sat_seen;
    int          send_idle = 0;
    int          recv_stall = 0;
    int          quiet = 0;
    int          sent = 0;

    rmj_state_if s_if ();
    rmj_jac_if   j_if ();

    radar_measurement_jacobian_unit u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_state(s_if), .o_jac(j_if),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    radar_measurement_jacobian_checker u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .st(s_if), .jac(j_if),
        .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
        .paddr(paddr), .pwdata(pwdata), .o_errors(errors), .o_pending(pending),
        .o_results(results), .o_close_seen(close_seen), .o_sat_seen(sat_seen)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        s_if.valid = 1'b0;
        s_if.pos_x = 0;
        s_if.pos_y = 0;
        s_if.vel_x = 0;
        s_if.vel_y = 0;
        j_if.ready = 1'b0;
    end

    always @(negedge i_clk) j_if.ready <= $urandom_range(99) >= recv_stall;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_if.valid && s_if.ready) || (j_if.valid && j_if.ready)) quiet <= 0;
            else quiet <= quiet + 1;
            if (quiet >= WATCHDOG) begin
                $display("watchdog: no item moved for %0d cycles", WATCHDOG);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    task automatic reg_write(input logic [2:0] addr, input logic [31:0] val);
        @(negedge i_clk);
        psel   = 1'b1;
        pwrite = 1'b1;
        paddr  = addr;
        pwdata = val;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic send_state(input logic [31:0] px, input logic [31:0] py,
                              input logic [31:0] vx, input logic [31:0] vy);
        while ($urandom_range(99) < send_idle) @(negedge i_clk);
        s_if.valid = 1'b1;
        s_if.pos_x = px;
        s_if.pos_y = py;
        s_if.vel_x = vx;
        s_if.vel_y = vy;
        do @(posedge i_clk); while (!s_if.ready);
        @(negedge i_clk);
        s_if.valid = 1'b0;
        sent++;
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(3))
            0: return $urandom;
            1: return 32'($signed($urandom_range(1 << 19)) - (1 << 18));
            2: return 32'($signed($urandom_range(1 << 11)) - (1 << 10));
            default: return 32'($signed($urandom_range(1 << 27)) - (1 << 26));
        endcase
    endfunction

    task automatic drain();
        while (pending != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    initial begin
        logic [15:0] limits [6] = '{16'd0, 16'd65535, 16'd7, 16'd1, 16'd0, 16'd300};
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed items at the reset limit
        send_state(0, 0, 32'h0001_0000, 32'h0001_0000);
        send_state(32'h0000_0100, 0, 0, 0);
        send_state(32'h0000_0280, 32'h0000_0200, 32'h7FFF_FFFF, 32'h8000_0000);
        send_state(32'h0000_0300, 0, 5, 5);
        send_state(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
        send_state(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_state(32'h8000_0000, 0, 32'h7FFF_FFFF, 32'h8000_0000);
        send_state(0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
        send_state(32'hFFFF_FD00, 32'h0000_0010, 32'h0100_0000, 32'hFF00_0000);
        send_state(32'h0001_0000, 32'h0001_0000, 32'h0002_0000, 32'hFFFE_0000);
        send_state(32'hFFFF_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
        send_state(32'h0000_0001, 32'h0000_0400, 32'h7FFF_FFFF, 32'h0000_0001);
        send_state(32'h0030_0000, 32'hFFC0_0000, 32'h0000_8000, 32'hFFFF_8000);
        send_state(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0);
        drain();

        reg_write(3'd4, 32'hFFFF_0000);
        reg_write(3'd0, 32'd0);
        send_state(32'h0000_0001, 0, 32'h0001_0000, 0);
        send_state(0, 0, 0, 0);
        send_state(0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        drain();
        reg_write(3'd0, 32'hFFFF_FFFF);
        send_state(32'h0000_FFFF, 0, 0, 0);
        send_state(32'h0001_0000, 0, 0, 0);
        send_state(32'h0000_B505, 32'h0000_B505, 1, 2);
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 55; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 55; end
                default: begin send_idle = 22; recv_stall = 22; end
            endcase
            reg_write(3'd0, ph < 6 ? {16'd0, limits[ph]} : $urandom);
            repeat (80) send_state(rand_word(), rand_word(), rand_word(), rand_word());
            drain();
        end
        send_idle  = 0;
        recv_stall = 0;
        repeat (80) @(posedge i_clk);

        $display("%0d state items sent, %0d results checked (%0d refused, %0d clipped)",
                 sent, results, close_seen, sat_seen);
        $display("eight random phases over limits 0 to 65535 and four stall patterns");
        if (errors == 0 && pending == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end

endmodule
